@@ sv/lrt_pkg.sv @@
`timescale 1ns / 1ps

package lrt_pkg;

	// default geometry
	localparam int DEF_ENTRIES    = 32;
	localparam int DEF_KEY_BITS   = 8;
	localparam int DEF_COUNT_BITS = 16;

	// capacity register
	localparam int               CAP_BITS  = 6;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 6'd32;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_DONE
	} lrt_state_t;

	// per-cell update commands, mutually exclusive
	typedef struct packed {
		logic inc;       // hit: bump the count, saturating
		logic load_new;  // take the access key with count one
		logic shift;     // take the right neighbor's entry
	} lrt_cell_ctrl_t;

endpackage

@@ sv/lfu_replacement_table_core.sv @@
`timescale 1ns / 1ps

// LFU replacement table: a row of ENTRIES cells holds keys and use counts in
// insertion order, entry 0 the oldest. One access is handled at a time. For a
// hit or a miss with free room, the access goes through the lookup and done
// states and its result is then registered onto out_valid; the next access is
// taken once the block is back in idle. The lookup compares all cells at once.
// A miss on a full table walks a minimum token from cell 0 through the occupied
// cells, one cell a cycle, in a scan state between lookup and done. The victim
// then leaves and the cells behind it shift up by one, while the new key lands
// in the last occupied cell. A finished result waits in the output register
// while the next access is taken. A new result that finds that register still
// stalled holds the block until the register drains. Capacity may only be
// written while idle; 0 acts as 1 and values above ENTRIES act as ENTRIES.
module lfu_replacement_table_core #(
	parameter int ENTRIES    = lrt_pkg::DEF_ENTRIES,
	parameter int KEY_BITS   = lrt_pkg::DEF_KEY_BITS,
	parameter int COUNT_BITS = lrt_pkg::DEF_COUNT_BITS,
	localparam int FILL_W    = $clog2(ENTRIES + 1),
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [lrt_pkg::CAP_BITS-1:0] cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [KEY_BITS-1:0]          access_key,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic                         evicted_valid,
	output logic [KEY_BITS-1:0]          evicted_key,
	output logic [COUNT_BITS-1:0]        key_count,
	output logic [FILL_W-1:0]            occupancy
);

	lrt_pkg::lrt_state_t state_q, state_d;

	logic [lrt_pkg::CAP_BITS-1:0] cap_q;
	logic [FILL_W-1:0]            eff_cap;
	logic [FILL_W-1:0]            fill_q;
	logic [FILL_W-1:0]            scan_q;
	logic [KEY_BITS-1:0]          key_q;

	logic st_idle, st_lookup, st_scan, st_done;
	logic any_hit, full, inject, scan_done, out_free;

	logic [ENTRIES-1:0]    match;
	logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
	logic [COUNT_BITS-1:0] cell_count [ENTRIES];
	logic                  tok_v      [ENTRIES];
	logic [COUNT_BITS-1:0] tok_cnt    [ENTRIES];
	logic [IDX_W-1:0]      tok_idx    [ENTRIES];
	logic [KEY_BITS-1:0]   tok_key    [ENTRIES];
	lrt_pkg::lrt_cell_ctrl_t ctrl     [ENTRIES];

	logic [COUNT_BITS-1:0] hit_count;
	logic [IDX_W-1:0]      last_idx;
	logic [IDX_W-1:0]      victim;

	logic                  res_hit_q, res_ev_q;
	logic [KEY_BITS-1:0]   res_ev_key_q;
	logic [COUNT_BITS-1:0] res_count_q;

	logic                  out_v_q;
	logic                  out_hit_q, out_ev_q;
	logic [KEY_BITS-1:0]   out_ev_key_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic [FILL_W-1:0]     out_occ_q;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lrt_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// clamp capacity into 1..ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = FILL_W'(1);
		end else if (32'(cap_q) > ENTRIES) begin
			eff_cap = FILL_W'(ENTRIES);
		end else begin
			eff_cap = FILL_W'(cap_q);
		end
	end

	assign full      = (fill_q >= eff_cap);
	assign any_hit   = |match;
	assign out_free  = !out_v_q || !out_stall;
	assign scan_done = (scan_q == fill_q);
	assign last_idx  = IDX_W'(fill_q - FILL_W'(1));
	assign victim    = tok_idx[last_idx];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lrt_pkg::ST_IDLE:   if (in_valid) state_d = lrt_pkg::ST_LOOKUP;
			lrt_pkg::ST_LOOKUP: state_d = (!any_hit && full) ? lrt_pkg::ST_SCAN
			                                                  : lrt_pkg::ST_DONE;
			lrt_pkg::ST_SCAN:   if (scan_done) state_d = lrt_pkg::ST_DONE;
			lrt_pkg::ST_DONE:   if (out_free) state_d = lrt_pkg::ST_IDLE;
			default:            state_d = lrt_pkg::ST_IDLE;
		endcase
	end

	// state decodes
	always_comb begin
		st_idle   = 1'b0;
		st_lookup = 1'b0;
		st_scan   = 1'b0;
		st_done   = 1'b0;
		case (state_q)
			lrt_pkg::ST_IDLE:   st_idle   = 1'b1;
			lrt_pkg::ST_LOOKUP: st_lookup = 1'b1;
			lrt_pkg::ST_SCAN:   st_scan   = 1'b1;
			lrt_pkg::ST_DONE:   st_done   = 1'b1;
			default:            st_idle   = 1'b1;
		endcase
	end

	assign in_stall = !st_idle;
	assign inject   = st_lookup && !any_hit && full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrt_pkg::ST_IDLE;
			fill_q  <= '0;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			if (st_lookup && !any_hit && !full) fill_q <= fill_q + FILL_W'(1);
			if (inject) begin
				scan_q <= FILL_W'(1);
			end else if (st_scan && !scan_done) begin
				scan_q <= scan_q + FILL_W'(1);
			end
		end
	end

	// hold the access key
	always_ff @(posedge clk) begin
		if (st_idle && in_valid) key_q <= access_key;
	end

	// count of the matching cell, one-hot select
	always_comb begin
		hit_count = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) hit_count = hit_count | cell_count[i];
		end
	end

	// cell commands and the chain
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic [KEY_BITS-1:0]   nbr_key;
		logic [COUNT_BITS-1:0] nbr_count;
		logic                  tin_v, tin_first;
		logic [COUNT_BITS-1:0] tin_cnt;
		logic [IDX_W-1:0]      tin_idx;
		logic [KEY_BITS-1:0]   tin_key;

		assign ctrl[i].inc      = st_lookup && match[i];
		assign ctrl[i].load_new = (st_lookup && !any_hit && !full && (fill_q == FILL_W'(i)))
		                       || (st_scan && scan_done && (last_idx == IDX_W'(i)));
		assign ctrl[i].shift    = st_scan && scan_done && (IDX_W'(i) >= victim)
		                       && ((FILL_W'(i) + FILL_W'(1)) < fill_q);

		if (i == ENTRIES - 1) begin : g_tail
			assign nbr_key   = '0;
			assign nbr_count = '0;
		end else begin : g_body
			assign nbr_key   = cell_key[i+1];
			assign nbr_count = cell_count[i+1];
		end

		if (i == 0) begin : g_head
			assign tin_v     = inject;
			assign tin_first = 1'b1;
			assign tin_cnt   = '0;
			assign tin_idx   = '0;
			assign tin_key   = '0;
		end else begin : g_link
			assign tin_v     = tok_v[i-1];
			assign tin_first = 1'b0;
			assign tin_cnt   = tok_cnt[i-1];
			assign tin_idx   = tok_idx[i-1];
			assign tin_key   = tok_key[i-1];
		end

		lrt_cell #(
			.KEY_BITS  (KEY_BITS),
			.COUNT_BITS(COUNT_BITS),
			.IDX_W     (IDX_W),
			.CELL_IDX  (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl[i]),
			.lookup_key  (key_q),
			.nbr_key     (nbr_key),
			.nbr_count   (nbr_count),
			.tok_in_v    (tin_v),
			.tok_in_first(tin_first),
			.tok_in_cnt  (tin_cnt),
			.tok_in_idx  (tin_idx),
			.tok_in_key  (tin_key),
			.match       (match[i]),
			.key         (cell_key[i]),
			.count       (cell_count[i]),
			.tok_out_v   (tok_v[i]),
			.tok_out_cnt (tok_cnt[i]),
			.tok_out_idx (tok_idx[i]),
			.tok_out_key (tok_key[i])
		);
	end

	// collect the result
	always_ff @(posedge clk) begin
		if (st_lookup) begin
			res_hit_q    <= any_hit;
			res_ev_q     <= 1'b0;
			res_ev_key_q <= '0;
			if (any_hit) begin
				res_count_q <= (hit_count != '1) ? hit_count + COUNT_BITS'(1) : hit_count;
			end else begin
				res_count_q <= COUNT_BITS'(1);
			end
		end else if (st_scan && scan_done) begin
			res_ev_q     <= 1'b1;
			res_ev_key_q <= tok_key[last_idx];
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (st_done && out_free) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_done && out_free) begin
			out_hit_q    <= res_hit_q;
			out_ev_q     <= res_ev_q;
			out_ev_key_q <= res_ev_key_q;
			out_count_q  <= res_count_q;
			out_occ_q    <= fill_q;
		end
	end

	assign out_valid     = out_v_q;
	assign hit           = out_hit_q;
	assign evicted_valid = out_ev_q;
	assign evicted_key   = out_ev_key_q;
	assign key_count     = out_count_q;
	assign occupancy     = out_occ_q;

endmodule

@@ sv/lrt_cell.sv @@
`timescale 1ns / 1ps

module lrt_cell #(
	parameter int KEY_BITS   = lrt_pkg::DEF_KEY_BITS,
	parameter int COUNT_BITS = lrt_pkg::DEF_COUNT_BITS,
	parameter int IDX_W      = 5,
	parameter int CELL_IDX   = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrt_pkg::lrt_cell_ctrl_t ctrl,
	input  logic [KEY_BITS-1:0]   lookup_key,
	input  logic [KEY_BITS-1:0]   nbr_key,
	input  logic [COUNT_BITS-1:0] nbr_count,
	input  logic                  tok_in_v,
	input  logic                  tok_in_first,
	input  logic [COUNT_BITS-1:0] tok_in_cnt,
	input  logic [IDX_W-1:0]      tok_in_idx,
	input  logic [KEY_BITS-1:0]   tok_in_key,
	output logic                  match,
	output logic [KEY_BITS-1:0]   key,
	output logic [COUNT_BITS-1:0] count,
	output logic                  tok_out_v,
	output logic [COUNT_BITS-1:0] tok_out_cnt,
	output logic [IDX_W-1:0]      tok_out_idx,
	output logic [KEY_BITS-1:0]   tok_out_key
);

	logic [KEY_BITS-1:0]   key_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  tok_v_q;
	logic [COUNT_BITS-1:0] tok_cnt_q;
	logic [IDX_W-1:0]      tok_idx_q;
	logic [KEY_BITS-1:0]   tok_key_q;
	logic                  take_own;

	// a live entry always has a nonzero count
	assign match = (count_q != '0) && (key_q == lookup_key);
	assign key   = key_q;
	assign count = count_q;

	// update the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.inc) begin
			if (count_q != '1) count_q <= count_q + COUNT_BITS'(1);
		end else if (ctrl.load_new) begin
			count_q <= COUNT_BITS'(1);
		end else if (ctrl.shift) begin
			count_q <= nbr_count;
		end
	end

	// update the entry key
	always_ff @(posedge clk) begin
		if (ctrl.load_new) begin
			key_q <= lookup_key;
		end else if (ctrl.shift) begin
			key_q <= nbr_key;
		end
	end

	// minimum token: strictly lower count wins, so the oldest keeps a tie
	assign take_own = tok_in_first || (count_q < tok_in_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_v_q <= 1'b0;
		end else begin
			tok_v_q <= tok_in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in_v) begin
			if (take_own) begin
				tok_cnt_q <= count_q;
				tok_idx_q <= IDX_W'(CELL_IDX);
				tok_key_q <= key_q;
			end else begin
				tok_cnt_q <= tok_in_cnt;
				tok_idx_q <= tok_in_idx;
				tok_key_q <= tok_in_key;
			end
		end
	end

	assign tok_out_v   = tok_v_q;
	assign tok_out_cnt = tok_cnt_q;
	assign tok_out_idx = tok_idx_q;
	assign tok_out_key = tok_key_q;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int ENTRIES    = lrt_pkg::DEF_ENTRIES;
	localparam int KEY_BITS   = lrt_pkg::DEF_KEY_BITS;
	localparam int COUNT_BITS = lrt_pkg::DEF_COUNT_BITS;
	localparam int CAP_BITS   = lrt_pkg::CAP_BITS;
	localparam int FILL_W     = $clog2(ENTRIES + 1);
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic                  hit;
		logic                  ev_valid;
		logic [KEY_BITS-1:0]   ev_key;
		logic [COUNT_BITS-1:0] count;
		logic [FILL_W-1:0]     occ;
	} lookup_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CAP_BITS-1:0]   cfg_wr_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [KEY_BITS-1:0]   access_key = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  hit;
	logic                  evicted_valid;
	logic [KEY_BITS-1:0]   evicted_key;
	logic [COUNT_BITS-1:0] key_count;
	logic [FILL_W-1:0]     occupancy;

	// shadow table for prediction
	logic [KEY_BITS-1:0]   tbl_key [ENTRIES];
	logic [COUNT_BITS-1:0] tbl_count [ENTRIES];
	int                    tbl_fill = 0;
	logic [CAP_BITS-1:0]   cap_reg = lrt_pkg::CAP_RESET;

	lookup_result_t expected_results [$];
	int mismatches = 0;
	int send_idle_pct = 22;
	int recv_idle_pct = 74;
	int quiet_cycles = 0;

	lfu_replacement_table_core #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.COUNT_BITS(COUNT_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.access_key   (access_key),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.evicted_valid(evicted_valid),
		.evicted_key  (evicted_key),
		.key_count    (key_count),
		.occupancy    (occupancy)
	);

	// free-running clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// apply one access to the shadow table and return what the block should report
	function automatic lookup_result_t predict_access(input logic [KEY_BITS-1:0] key);
		lookup_result_t res;
		int lim;
		int victim;
		logic found;
		res = '0;
		found = 1'b0;
		for (int i = 0; i < tbl_fill; i++) begin
			if (!found && tbl_key[i] == key) begin
				if (tbl_count[i] != '1)
					tbl_count[i] = tbl_count[i] + 1'b1;
				res.count = tbl_count[i];
				found = 1'b1;
			end
		end
		res.hit = found;
		if (!found) begin
			// clamp capacity into 1..ENTRIES
			lim = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg));
			if (tbl_fill < lim) begin
				tbl_key[tbl_fill] = key;
				tbl_count[tbl_fill] = COUNT_BITS'(1);
				tbl_fill++;
			end else begin
				// lowest count wins, oldest entry on a tie
				victim = 0;
				for (int i = 1; i < tbl_fill; i++)
					if (tbl_count[i] < tbl_count[victim])
						victim = i;
				res.ev_valid = 1'b1;
				res.ev_key = tbl_key[victim];
				for (int i = victim; i + 1 < tbl_fill; i++) begin
					tbl_key[i] = tbl_key[i + 1];
					tbl_count[i] = tbl_count[i + 1];
				end
				tbl_key[tbl_fill - 1] = key;
				tbl_count[tbl_fill - 1] = COUNT_BITS'(1);
			end
			res.count = COUNT_BITS'(1);
		end
		res.occ = FILL_W'(tbl_fill);
		return res;
	endfunction

	// append one predicted result at the tail of the queue
	task automatic enqueue_expected(input lookup_result_t r);
		expected_results = {expected_results, r};
	endtask

	task automatic check_field(input string name, input logic [COUNT_BITS-1:0] want_v,
		input logic [COUNT_BITS-1:0] got_v);
		if (want_v !== got_v) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
		end
	endtask

	// score result beats, then track config writes and accepted access beats
	always @(posedge clk) begin : result_check
		lookup_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$error("result beat with no access pending");
				end else begin
					want = expected_results.pop_front();
					check_field("hit", COUNT_BITS'(want.hit), COUNT_BITS'(hit));
					check_field("evicted_valid", COUNT_BITS'(want.ev_valid),
						COUNT_BITS'(evicted_valid));
					check_field("evicted_key", COUNT_BITS'(want.ev_key),
						COUNT_BITS'(evicted_key));
					check_field("key_count", want.count, key_count);
					check_field("occupancy", COUNT_BITS'(want.occ), COUNT_BITS'(occupancy));
				end
			end
			if (cfg_wr_en)
				cap_reg = cfg_wr_data;
			if (in_valid && !in_stall)
				enqueue_expected(predict_access(access_key));
		end
	end

	// random back-pressure on the result side
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// end the run when no beat moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("lfu_replacement_table_core: mismatch");
				$finish;
			end
		end
	end

	// present one access key, with random gaps, and hold it until taken
	task automatic drive_access(input logic [KEY_BITS-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			access_key <= KEY_BITS'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		access_key <= key;
		do @(posedge clk); while (in_stall);
	endtask

	// hold off until every pending result has come back
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (expected_results.size() != 0);
		@(posedge clk);
	endtask

	// write capacity only with the block idle
	task automatic write_capacity(input logic [CAP_BITS-1:0] value);
		wait_results_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// capacity 0 behaves as a single entry: every new key replaces the last
	task automatic test_capacity_floor();
		write_capacity('0);
		drive_access(8'h00);
		drive_access(8'hFF);
		drive_access(8'hFF);
		drive_access(8'h80);
		drive_access(8'h7F);
	endtask

	// two entries: lowest count leaves, oldest on a tie
	task automatic test_tie_break();
		write_capacity(CAP_BITS'(2));
		drive_access(8'h55);
		drive_access(8'h55);
		drive_access(8'hAA);
		drive_access(8'h01);
		drive_access(8'h02);
		drive_access(8'h02);
		drive_access(8'h03);
	endtask

	// capacity below the fill level: misses replace, occupancy holds
	task automatic test_capacity_below_fill();
		write_capacity(CAP_BITS'(1));
		drive_access(8'hC3);
		drive_access(8'h3C);
		drive_access(8'h3C);
		drive_access(8'hE7);
	endtask

	// random keys, mostly drawn from a pool a bit larger than the capacity
	task automatic test_random_stream();
		logic [CAP_BITS-1:0] caps [5];
		int lens [5];
		int sent;
		int span;
		logic [KEY_BITS-1:0] base;
		logic [KEY_BITS-1:0] key;
		caps = '{CAP_BITS'(8), CAP_BITS'(20), CAP_BITS'(63), CAP_BITS'(3), CAP_BITS'(32)};
		lens = '{300, 300, 400, 250, 300};
		sent = 0;
		for (int p = 0; p < 5; p++) begin
			write_capacity(caps[p]);
			base = KEY_BITS'($urandom);
			span = ((caps[p] > ENTRIES) ? ENTRIES : int'(caps[p])) + 4;
			for (int n = 0; n < lens[p]; n++) begin
				if (sent < 517) begin
					send_idle_pct = 22;
					recv_idle_pct = 74;
				end else if (sent < 1034) begin
					send_idle_pct = 74;
					recv_idle_pct = 22;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				if ($urandom_range(99) < 75)
					key = base + KEY_BITS'($urandom_range(span - 1));
				else
					key = KEY_BITS'($urandom);
				drive_access(key);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_capacity_floor();
		test_tie_break();
		test_capacity_below_fill();
		test_random_stream();
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("lfu_replacement_table_core: match");
		else
			$display("lfu_replacement_table_core: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
sv/lrt_pkg.sv
sv/lrt_cell.sv
sv/lfu_replacement_table_core.sv
verif/testbench.sv
